FILE: hdl/lebuf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line edit buffer package
// Shared sizes, request and status codes, and the result word type that
// passes from the edit sequencer to the output stage.
// ----------------------------------------------------------------------------
package lebuf_pkg;

   // Buffer size and the widths that follow from it.
   localparam int LineCapacity = 256;
   localparam int AddrWidth    = $clog2(LineCapacity);
   localparam int CountWidth   = $clog2(LineCapacity + 1);

   // Character codes with a meaning of their own.
   localparam logic [7:0] CharNewline = 8'd10;
   localparam logic [7:0] CharSpace   = 8'd32;

   // Request codes.
   typedef enum logic [2:0] {
      REQ_CHAR   = 3'd0,
      REQ_LEFT   = 3'd1,
      REQ_RIGHT  = 3'd2,
      REQ_BACK   = 3'd3,
      REQ_DEL    = 3'd4,
      REQ_ENTER  = 3'd5,
      REQ_TOGGLE = 3'd6,
      REQ_READ   = 3'd7
   } req_code_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_APPLIED = 2'd0,
      ST_IGNORED = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   // One result word together with its valid flag.
   typedef struct packed {
      logic                  valid;
      logic [CountWidth-1:0] cursor_pos;
      logic [CountWidth-1:0] line_length;
      logic                  overwrite_on;
      logic                  finished;
      logic [7:0]            read_data;
      status_type            status;
   } result_type;

endpackage : lebuf_pkg
`default_nettype wire

FILE: hdl/lebuf_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read; a read of the
// address being written returns the old contents.
// ----------------------------------------------------------------------------
module lebuf_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule : lebuf_ram
`default_nettype wire

FILE: hdl/lebuf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line edit buffer sequencer
// Holds cursor, length and mode, decodes each request word and runs the
// shift passes over the line memory one entry per cycle.
// ----------------------------------------------------------------------------
module lebuf_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [2:0]                       req_type,
   input  wire logic                             req_pressed,
   input  wire logic [7:0]                       req_char_code,
   input  wire logic [7:0]                       req_read_index,
   output lebuf_pkg::result_type                 res,
   input  wire logic                             res_take,
   output logic                                  ram_wr_en,
   output logic      [lebuf_pkg::AddrWidth-1:0]  ram_wr_addr,
   output logic      [7:0]                       ram_wr_data,
   output logic      [lebuf_pkg::AddrWidth-1:0]  ram_rd_addr,
   input  wire logic [7:0]                       ram_rd_data
);
   import lebuf_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_INSERT = 5'b00010,
      S_REMOVE = 5'b00100,
      S_READ   = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [CountWidth-1:0] cursor_ff, cursor_in;
   logic [CountWidth-1:0] length_ff, length_in;
   logic                  overwrite_ff, overwrite_in;
   logic                  done_ff, done_in;
   logic [CountWidth-1:0] ptr_ff, ptr_in;
   logic                  pend_ff, pend_in;
   logic [AddrWidth-1:0]  pend_addr_ff, pend_addr_in;
   logic                  back_ff, back_in;
   logic                  idx_ok_ff, idx_ok_in;
   logic [7:0]            char_ff, char_in;
   logic [7:0]            rdata_ff, rdata_in;
   status_type            status_ff, status_in;

   req_code_type          code;
   logic                  accept;
   logic                  printable;
   logic [CountWidth-1:0] ptr_dec;
   logic [CountWidth-1:0] ptr_inc;
   logic [CountWidth-1:0] cursor_dec;

   assign code       = req_code_type'(req_type);
   assign accept     = req_valid && (state_ff == S_IDLE);
   assign req_stall  = (state_ff != S_IDLE);
   assign ptr_dec    = ptr_ff - 1'b1;
   assign ptr_inc    = ptr_ff + 1'b1;
   assign cursor_dec = cursor_ff - 1'b1;

   // Letters, digits and space are stored; other codes but newline are dropped.
   always_comb begin
      printable = (req_char_code inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39]})
                  || (req_char_code == CharSpace);
   end

   // Result word; state registers already hold their final values in S_DONE.
   always_comb begin
      res.valid        = (state_ff == S_DONE);
      res.cursor_pos   = cursor_ff;
      res.line_length  = length_ff;
      res.overwrite_on = overwrite_ff;
      res.finished     = done_ff;
      res.read_data    = rdata_ff;
      res.status       = status_ff;
   end

   // Request decode and shift sequencing.
   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      length_in    = length_ff;
      overwrite_in = overwrite_ff;
      done_in      = done_ff;
      ptr_in       = ptr_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      back_in      = back_ff;
      idx_ok_in    = idx_ok_ff;
      char_in      = char_ff;
      rdata_in     = rdata_ff;
      status_in    = status_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pend_addr_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_addr  = req_read_index;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rdata_in  = 8'd0;
               status_in = ST_IGNORED;
               state_in  = S_DONE;
               char_in   = req_char_code;
               pend_in   = 1'b0;
               if (code == REQ_READ) begin
                  // The memory read issues now; the data lands next cycle.
                  idx_ok_in = ({1'b0, req_read_index} < length_ff);
                  state_in  = S_READ;
               end else if (done_ff) begin
                  status_in = ST_IGNORED;
               end else if (code == REQ_CHAR) begin
                  if (req_char_code == CharNewline) begin
                     done_in   = 1'b1;
                     status_in = ST_APPLIED;
                  end else if (printable) begin
                     if (overwrite_ff && (cursor_ff < length_ff)) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = cursor_ff[AddrWidth-1:0];
                        ram_wr_data = req_char_code;
                        cursor_in   = cursor_ff + 1'b1;
                        status_in   = ST_APPLIED;
                     end else if (length_ff >= CountWidth'(LineCapacity)) begin
                        status_in = ST_FULL;
                     end else begin
                        ptr_in   = length_ff;
                        state_in = S_INSERT;
                     end
                  end
               end else if (req_pressed) begin
                  case (code)
                     REQ_LEFT: begin
                        if (cursor_ff != '0) begin
                           cursor_in = cursor_dec;
                           status_in = ST_APPLIED;
                        end
                     end
                     REQ_RIGHT: begin
                        if (cursor_ff < length_ff) begin
                           cursor_in = cursor_ff + 1'b1;
                           status_in = ST_APPLIED;
                        end
                     end
                     REQ_BACK: begin
                        if (cursor_ff != '0) begin
                           ptr_in   = cursor_dec;
                           back_in  = 1'b1;
                           state_in = S_REMOVE;
                        end
                     end
                     REQ_DEL: begin
                        if (cursor_ff < length_ff) begin
                           ptr_in   = cursor_ff;
                           back_in  = 1'b0;
                           state_in = S_REMOVE;
                        end
                     end
                     REQ_ENTER: begin
                        done_in   = 1'b1;
                        status_in = ST_APPLIED;
                     end
                     REQ_TOGGLE: begin
                        overwrite_in = ~overwrite_ff;
                        status_in    = ST_APPLIED;
                     end
                     default: begin
                        status_in = ST_IGNORED;
                     end
                  endcase
               end
            end
         end

         // Shift the tail up one entry, top down: read entry ptr-1 while
         // writing the word read last cycle into the entry above it.
         S_INSERT: begin
            ram_wr_en = pend_ff;
            if (ptr_ff > cursor_ff) begin
               ram_rd_addr  = ptr_dec[AddrWidth-1:0];
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff[AddrWidth-1:0];
               ptr_in       = ptr_dec;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = cursor_ff[AddrWidth-1:0];
                  ram_wr_data = char_ff;
                  cursor_in   = cursor_ff + 1'b1;
                  length_in   = length_ff + 1'b1;
                  status_in   = ST_APPLIED;
                  state_in    = S_DONE;
               end
            end
         end

         // Shift the tail down one entry, bottom up: read entry ptr+1 while
         // writing the word read last cycle into the entry below it.
         S_REMOVE: begin
            ram_wr_en = pend_ff;
            if (ptr_inc < length_ff) begin
               ram_rd_addr  = ptr_inc[AddrWidth-1:0];
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff[AddrWidth-1:0];
               ptr_in       = ptr_inc;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  length_in = length_ff - 1'b1;
                  if (back_ff) begin
                     cursor_in = cursor_dec;
                  end
                  status_in = ST_APPLIED;
                  state_in  = S_DONE;
               end
            end
         end

         // Read data from the accept cycle is now on the memory output.
         S_READ: begin
            rdata_in  = idx_ok_ff ? ram_rd_data : 8'd0;
            status_in = ST_APPLIED;
            state_in  = S_DONE;
         end

         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_ff    <= '0;
         length_ff    <= '0;
         overwrite_ff <= 1'b0;
         done_ff      <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         length_ff    <= length_in;
         overwrite_ff <= overwrite_in;
         done_ff      <= done_in;
         pend_ff      <= pend_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      pend_addr_ff <= pend_addr_in;
      back_ff      <= back_in;
      idx_ok_ff    <= idx_ok_in;
      char_ff      <= char_in;
      rdata_ff     <= rdata_in;
      status_ff    <= status_in;
   end

endmodule : lebuf_ctrl
`default_nettype wire

FILE: hdl/line_edit_buffer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line edit buffer core
// Single-line character buffer with cursor, insert or overwrite mode and an
// end-of-line flag; the characters live in one synchronous RAM.
//
//   Channel   Direction   Handshake            Word
//   req_      in          req_valid/req_stall  type, pressed, char_code,
//                                              read_index
//   rsp_      out         rsp_valid/rsp_stall  cursor_pos, line_length,
//                                              overwrite_on, finished,
//                                              read_data, status
//
// One request word is in work at a time. Cursor moves, mode changes, enter,
// overwrites and refused words finish straight from the accept; a read waits
// for the registered RAM read, and an insert or erase first shifts the tail
// one entry per cycle through the RAM's single write port.
// Reset clears cursor, length and flags but not the RAM. A stalled result
// holds the sequencer only once its own next result is ready.
// ----------------------------------------------------------------------------
module line_edit_buffer_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [2:0]                         req_type,
   input  wire logic                               req_pressed,
   input  wire logic [7:0]                         req_char_code,
   input  wire logic [7:0]                         req_read_index,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [lebuf_pkg::CountWidth-1:0]   rsp_cursor_pos,
   output logic      [lebuf_pkg::CountWidth-1:0]   rsp_line_length,
   output logic                                    rsp_overwrite_on,
   output logic                                    rsp_finished,
   output logic      [7:0]                         rsp_read_data,
   output logic      [1:0]                         rsp_status
);
   import lebuf_pkg::*;

   result_type           res;
   logic                 res_take;
   logic                 ram_wr_en;
   logic [AddrWidth-1:0] ram_wr_addr;
   logic [7:0]           ram_wr_data;
   logic [AddrWidth-1:0] ram_rd_addr;
   logic [7:0]           ram_rd_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   result_type           rsp_word_ff;

   // Edit sequencer.
   lebuf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_pressed    (req_pressed),
      .req_char_code  (req_char_code),
      .req_read_index (req_read_index),
      .res            (res),
      .res_take       (res_take),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   // Character store.
   lebuf_ram #(
      .Width (8),
      .Depth (LineCapacity)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The output register loads when empty or when its word is being taken.
   assign res_take = res.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_word_ff <= res;
      end
   end

   // Result ports.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_pos   = rsp_word_ff.cursor_pos;
   assign rsp_line_length  = rsp_word_ff.line_length;
   assign rsp_overwrite_on = rsp_word_ff.overwrite_on;
   assign rsp_finished     = rsp_word_ff.finished;
   assign rsp_read_data    = rsp_word_ff.read_data;
   assign rsp_status       = rsp_word_ff.status;

endmodule : line_edit_buffer_core
`default_nettype wire
